@@ hw/rtl/cdtp_pkg.sv @@
package cdtp_pkg;

  // Default pool size
  localparam int NUM_TIMERS_DEF = 16;

  // Field widths fixed by the item format
  localparam int OP_W    = 3;
  localparam int ID_W    = 4;
  localparam int COUNT_W = 32;
  localparam int QUERY_W = 2;

  // Operation codes; the two spare codes are rejected
  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 3'd0,
    OP_FREE  = 3'd1,
    OP_SET   = 3'd2,
    OP_GET   = 3'd3,
    OP_CLEAR = 3'd4,
    OP_TICK  = 3'd5
  } op_t;

  // Get results
  typedef enum logic [QUERY_W-1:0] {
    Q_FIRED   = 2'd0,
    Q_RUNNING = 2'd1,
    Q_IDLE    = 2'd2
  } query_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC,
    S_GET,
    S_TICK,
    S_DONE
  } state_t;

endpackage

@@ hw/rtl/countdown_timer_pool_unit.sv @@
// Pool of countdown timers driven by one opcode per input beat.
// Input channel: in_valid/in_ready with in_opcode, in_timer_id and in_load_value.
// Result channel: out_valid/out_ready with out_ok, out_slot_index,
// out_query_state and out_tick_count; exactly one result beat per input beat.
// Counts live in a single-port-write memory with a registered read;
// allocate, running and count-written marks are flip-flop vectors.
// Free, set, clear and rejected opcodes pass through execute and done; get of
// a running slot adds a count read, allocate checks one slot per cycle, and
// tick does one memory read and one write-back per slot, overlapped.
// One item is worked on at a time; in_ready returns as soon as the result
// moves into the output register, so the next beat is taken while that
// result still waits for out_ready. When the receiver stalls, the finished
// result is held in the output register and the next item waits at its
// final step until the register frees.
// Reset (synchronous, rst_n low) frees all slots, stops them, marks every
// count as zero and clears the tick counter; no clearing pass is needed.
module countdown_timer_pool_unit
  import cdtp_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_opcode,
  input  logic [ID_W-1:0]    in_timer_id,
  input  logic [COUNT_W-1:0] in_load_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_ok,
  output logic [ID_W-1:0]    out_slot_index,
  output logic [QUERY_W-1:0] out_query_state,
  output logic [COUNT_W-1:0] out_tick_count
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  // Control state
  state_t                  state_r, state_nxt;
  logic [NUM_TIMERS-1:0]   alloc_r, alloc_nxt;
  logic [NUM_TIMERS-1:0]   run_r, run_nxt;
  logic [NUM_TIMERS-1:0]   cvld_r, cvld_nxt;
  logic [COUNT_W-1:0]      ticks_r, ticks_nxt;
  logic [CNT_W-1:0]        scan_r, scan_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Payload state
  op_t                     op_r, op_nxt;
  logic [ID_W-1:0]         id_r, id_nxt;
  logic [COUNT_W-1:0]      load_r, load_nxt;
  logic [IDX_W-1:0]        rd_idx_r, rd_idx_nxt;
  logic                    res_ok_r, res_ok_nxt;
  logic [ID_W-1:0]         res_slot_r, res_slot_nxt;
  query_t                  res_q_r, res_q_nxt;
  logic                    out_ok_r, out_ok_nxt;
  logic [ID_W-1:0]         out_slot_r, out_slot_nxt;
  query_t                  out_q_r, out_q_nxt;
  logic [COUNT_W-1:0]      out_tick_r, out_tick_nxt;

  // Count memory
  logic [COUNT_W-1:0]      cnt_mem [NUM_TIMERS];
  logic [COUNT_W-1:0]      mem_rdata_r;
  logic [IDX_W-1:0]        mem_raddr;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [COUNT_W-1:0]      mem_wdata;

  // Decode helpers
  logic [IDX_W-1:0]        id_sel;
  logic [IDX_W-1:0]        scan_sel;
  logic                    id_ok;
  logic                    usable;
  logic [COUNT_W-1:0]      rd_count;
  logic                    out_free;

  assign id_sel   = IDX_W'(id_r);
  assign scan_sel = scan_r[IDX_W-1:0];
  assign id_ok    = (32'(id_r) < 32'(NUM_TIMERS));
  assign usable   = id_ok && alloc_r[id_sel];
  // Unwritten counts read as zero
  assign rd_count = cvld_r[rd_idx_r] ? mem_rdata_r : '0;
  assign out_free = !out_valid_r || out_ready;

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= cnt_mem[mem_raddr];
  end

  // Next state, memory control and results
  always_comb begin
    state_nxt     = state_r;
    alloc_nxt     = alloc_r;
    run_nxt       = run_r;
    cvld_nxt      = cvld_r;
    ticks_nxt     = ticks_r;
    scan_nxt      = scan_r;
    rd_pend_nxt   = rd_pend_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    load_nxt      = load_r;
    rd_idx_nxt    = rd_idx_r;
    res_ok_nxt    = res_ok_r;
    res_slot_nxt  = res_slot_r;
    res_q_nxt     = res_q_r;
    out_ok_nxt    = out_ok_r;
    out_slot_nxt  = out_slot_r;
    out_q_nxt     = out_q_r;
    out_tick_nxt  = out_tick_r;
    mem_raddr     = id_sel;
    mem_we        = 1'b0;
    mem_waddr     = id_sel;
    mem_wdata     = load_r;
    in_ready      = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt    = op_t'(in_opcode);
          id_nxt    = in_timer_id;
          load_nxt  = in_load_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        res_ok_nxt   = 1'b0;
        res_slot_nxt = '0;
        res_q_nxt    = Q_IDLE;
        state_nxt    = S_DONE;
        case (op_r)
          OP_ALLOC: begin
            scan_nxt  = '0;
            state_nxt = S_ALLOC;
          end
          OP_FREE: begin
            if (usable) begin
              alloc_nxt[id_sel] = 1'b0;
              run_nxt[id_sel]   = 1'b0;
              res_ok_nxt        = 1'b1;
            end
          end
          OP_SET: begin
            if (usable) begin
              mem_we           = 1'b1;
              cvld_nxt[id_sel] = 1'b1;
              run_nxt[id_sel]  = 1'b1;
              res_ok_nxt       = 1'b1;
            end
          end
          OP_GET: begin
            res_ok_nxt = usable;
            // Running slot: fetch its count
            if (usable && run_r[id_sel]) begin
              rd_idx_nxt = id_sel;
              state_nxt  = S_GET;
            end
          end
          OP_CLEAR: begin
            if (usable) begin
              run_nxt[id_sel] = 1'b0;
              res_ok_nxt      = 1'b1;
            end
          end
          OP_TICK: begin
            scan_nxt    = '0;
            rd_pend_nxt = 1'b0;
            state_nxt   = S_TICK;
          end
          default: begin
            res_ok_nxt = 1'b0;
          end
        endcase
      end

      // Check one slot per cycle, lowest first
      S_ALLOC: begin
        if (scan_r == CNT_W'(NUM_TIMERS)) begin
          res_ok_nxt   = 1'b0;
          res_slot_nxt = '0;
          state_nxt    = S_DONE;
        end else if (!alloc_r[scan_sel]) begin
          alloc_nxt[scan_sel] = 1'b1;
          run_nxt[scan_sel]   = 1'b0;
          res_ok_nxt          = 1'b1;
          res_slot_nxt        = ID_W'(scan_r);
          state_nxt           = S_DONE;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_GET: begin
        res_q_nxt = (rd_count == '0) ? Q_FIRED : Q_RUNNING;
        state_nxt = S_DONE;
      end

      // Read slot k while writing back slot k-1
      S_TICK: begin
        if (rd_pend_r && (rd_count != '0)) begin
          mem_we            = 1'b1;
          mem_waddr         = rd_idx_r;
          mem_wdata         = rd_count - 1'b1;
          cvld_nxt[rd_idx_r] = 1'b1;
        end
        if (scan_r != CNT_W'(NUM_TIMERS)) begin
          mem_raddr   = scan_sel;
          rd_idx_nxt  = scan_sel;
          rd_pend_nxt = 1'b1;
          scan_nxt    = scan_r + 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
          if (!rd_pend_r) begin
            ticks_nxt  = ticks_r + 1'b1;
            res_ok_nxt = 1'b1;
            state_nxt  = S_DONE;
          end
        end
      end

      // Hand the result to the output register when it frees
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_slot_nxt  = res_slot_r;
          out_q_nxt     = res_q_r;
          out_tick_nxt  = ticks_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alloc_r     <= '0;
      run_r       <= '0;
      cvld_r      <= '0;
      ticks_r     <= '0;
      scan_r      <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alloc_r     <= alloc_nxt;
      run_r       <= run_nxt;
      cvld_r      <= cvld_nxt;
      ticks_r     <= ticks_nxt;
      scan_r      <= scan_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    load_r     <= load_nxt;
    rd_idx_r   <= rd_idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_slot_r <= res_slot_nxt;
    res_q_r    <= res_q_nxt;
    out_ok_r   <= out_ok_nxt;
    out_slot_r <= out_slot_nxt;
    out_q_r    <= out_q_nxt;
    out_tick_r <= out_tick_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_slot_index  = out_slot_r;
  assign out_query_state = out_q_r;
  assign out_tick_count  = out_tick_r;

endmodule

@@ hw/rtl/cdtp_checker.sv @@
module cdtp_checker
  import cdtp_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [OP_W-1:0]    in_opcode,
  input logic [ID_W-1:0]    in_timer_id,
  input logic [COUNT_W-1:0] in_load_value,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_ok,
  input logic [ID_W-1:0]    out_slot_index,
  input logic [QUERY_W-1:0] out_query_state,
  input logic [COUNT_W-1:0] out_tick_count
);

  // Hold a waiting input beat
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode) && $stable(in_timer_id)
      && $stable(in_load_value))
    else $error("waiting input beat changed");

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_slot_index)
      && $stable(out_query_state) && $stable(out_tick_count))
    else $error("stalled result beat changed");

  // One item at a time: input closes right after a beat
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input beat taken while busy");

  // Failed items never grant a slot
  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_slot_index == '0 && out_query_state == Q_IDLE)
    else $error("failed result carries slot or query");

  // No result right after reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind countdown_timer_pool_unit cdtp_checker u_cdtp_checker (.*);

@@ dv/tb_countdown_timer_pool_unit.sv @@
`timescale 1ns / 1ps

module tb_countdown_timer_pool_unit;
  import cdtp_pkg::*;

  localparam int NUM_SLOTS = NUM_TIMERS_DEF;
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam logic [COUNT_W-1:0] LOAD_MAX = '1;
  localparam int ITEMS_PER_PHASE = 284;
  localparam int SETTLE_CYCLES = NUM_SLOTS + 8;

  typedef struct packed {
    logic               ok;
    logic [ID_W-1:0]    slot;
    logic [QUERY_W-1:0] qstate;
    logic [COUNT_W-1:0] ticks;
  } pool_reply_t;

  // Timer pool predictor and the replies it still waits for
  class timer_pool_scoreboard;
    bit                 allocated [NUM_SLOTS];
    bit                 running [NUM_SLOTS];
    bit [COUNT_W-1:0]   count_left [NUM_SLOTS];
    bit [COUNT_W-1:0]   ticks;
    pool_reply_t        pending_replies [$];
    int                 mismatch_count;

    // Apply one accepted request and queue the reply it should give
    function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                               logic [COUNT_W-1:0] load);
      pool_reply_t r;
      bit usable;
      bit granted;
      r.ok = 1'b0;
      r.slot = '0;
      r.qstate = Q_IDLE;
      usable = (int'(id) < NUM_SLOTS) && allocated[id];
      granted = 1'b0;
      case (op)
        OP_ALLOC: begin
          // Grant the lowest free slot
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!granted && !allocated[i]) begin
              allocated[i] = 1'b1;
              running[i] = 1'b0;
              r.ok = 1'b1;
              r.slot = i[ID_W-1:0];
              granted = 1'b1;
            end
          end
        end
        OP_FREE: begin
          if (usable) begin
            allocated[id] = 1'b0;
            running[id] = 1'b0;
            r.ok = 1'b1;
          end
        end
        OP_SET: begin
          if (usable) begin
            count_left[id] = load;
            running[id] = 1'b1;
            r.ok = 1'b1;
          end
        end
        OP_GET: begin
          if (usable) begin
            r.ok = 1'b1;
            if (running[id]) r.qstate = (count_left[id] == 0) ? Q_FIRED : Q_RUNNING;
          end
        end
        OP_CLEAR: begin
          if (usable) begin
            running[id] = 1'b0;
            r.ok = 1'b1;
          end
        end
        OP_TICK: begin
          // Counts keep running down even on freed or cleared slots
          ticks = ticks + 1;
          foreach (count_left[i]) if (count_left[i] != 0) count_left[i] = count_left[i] - 1;
          r.ok = 1'b1;
        end
        default: ;
      endcase
      r.ticks = ticks;
      pending_replies.push_back(r);
    endfunction

    function void report_field(string name, logic [COUNT_W-1:0] want_v,
                               logic [COUNT_W-1:0] got_v);
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      mismatch_count++;
    endfunction

    // Compare one result beat with the oldest queued reply
    function void check_reply(logic ok, logic [ID_W-1:0] slot,
                              logic [QUERY_W-1:0] qstate, logic [COUNT_W-1:0] ticks_out);
      pool_reply_t want;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got ok=%h slot=%h state=%h ticks=%h",
                 $time, ok, slot, qstate, ticks_out);
        mismatch_count++;
        return;
      end
      want = pending_replies.pop_front();
      if (ok !== want.ok) report_field("ok", COUNT_W'(want.ok), COUNT_W'(ok));
      if (slot !== want.slot)
        report_field("slot_index", COUNT_W'(want.slot), COUNT_W'(slot));
      if (qstate !== want.qstate)
        report_field("query_state", COUNT_W'(want.qstate), COUNT_W'(qstate));
      if (ticks_out !== want.ticks) report_field("tick_count", want.ticks, ticks_out);
    endfunction

    // Mostly address live slots so set, get and clear reach deep states
    function logic [ID_W-1:0] pick_slot();
      int live [$];
      foreach (allocated[i]) if (allocated[i]) live.push_back(i);
      if (live.size() == 0 || $urandom_range(0, 4) == 0)
        return ID_W'($urandom_range(0, 2**ID_W - 1));
      return ID_W'(live[$urandom_range(0, live.size() - 1)]);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_opcode = '0;
  logic [ID_W-1:0]    in_timer_id = '0;
  logic [COUNT_W-1:0] in_load_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_ok;
  logic [ID_W-1:0]    out_slot_index;
  logic [QUERY_W-1:0] out_query_state;
  logic [COUNT_W-1:0] out_tick_count;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  timer_pool_scoreboard sb;

  countdown_timer_pool_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_timer_id     (in_timer_id),
    .in_load_value   (in_load_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_ok          (out_ok),
    .out_slot_index  (out_slot_index),
    .out_query_state (out_query_state),
    .out_tick_count  (out_tick_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watch both channels and toggle the receiver's ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_reply(out_ok, out_slot_index, out_query_state, out_tick_count);
      if (in_valid && in_ready) sb.note_request(in_opcode, in_timer_id, in_load_value);
    end
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Present one request beat and hold it until accepted
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [COUNT_W-1:0] load);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_timer_id <= id;
    in_load_value <= load;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid and hold off until every queued reply has come back
  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending_replies.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] random_load();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 6);
    return $urandom;
  endfunction

  // Random traffic: mixed opcodes plus set-tick-get lifecycles
  task automatic run_random(input int n);
    int done;
    int pick;
    int steps;
    logic [OP_W-1:0] op;
    logic [ID_W-1:0] id;
    logic [COUNT_W-1:0] load;
    done = 0;
    while (done < n) begin
      pick = $urandom_range(0, 99);
      id = sb.pick_slot();
      load = random_load();
      if (pick < 8) begin
        steps = $urandom_range(0, 5);
        send_item(OP_SET, id, COUNT_W'(steps));
        repeat (steps + $urandom_range(0, 1)) send_item(OP_TICK, ID_W'($urandom), $urandom);
        send_item(OP_GET, id, $urandom);
        done += steps + 2;
      end else begin
        if (pick < 20) op = OP_ALLOC;
        else if (pick < 30) op = OP_FREE;
        else if (pick < 45) op = OP_SET;
        else if (pick < 66) op = OP_GET;
        else if (pick < 74) op = OP_CLEAR;
        else if (pick < 97) op = OP_TICK;
        else op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        send_item(op, id, load);
        if (op != OP_SPARE_A && op != OP_SPARE_B) done++;
      end
    end
  endtask

  initial begin
    sb = new();
    send_idle_pct = 14;
    recv_idle_pct = 51;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Fill the pool, then one allocate past full
    repeat (NUM_SLOTS + 1) send_item(OP_ALLOC, ID_W'($urandom), $urandom);
    // Free a slot, then touch it while unallocated
    send_item(OP_FREE, 4'd15, '0);
    send_item(OP_GET, 4'd15, '0);
    // Run one slot to zero and park another at the top count
    send_item(OP_SET, 4'd1, 32'd1);
    send_item(OP_SET, 4'd0, LOAD_MAX);
    send_item(OP_TICK, 4'd0, '0);
    send_item(OP_GET, 4'd1, '0);
    send_item(OP_GET, 4'd0, '0);
    // Stop a slot and confirm it reads as not running
    send_item(OP_CLEAR, 4'd0, '0);
    send_item(OP_GET, 4'd0, '0);
    send_item(OP_SPARE_A, 4'd15, LOAD_MAX);
    send_item(OP_SPARE_B, 4'd3, '0);

    run_random(ITEMS_PER_PHASE);
    wait_drained(1);

    send_idle_pct = 51;
    recv_idle_pct = 14;
    run_random(ITEMS_PER_PHASE);
    wait_drained(1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    wait_drained(SETTLE_CYCLES);

    @(negedge clk);
    if (sb.mismatch_count == 0 && sb.pending_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Bound the run in case the block hangs
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cdtp_pkg.sv
hw/rtl/countdown_timer_pool_unit.sv
hw/rtl/cdtp_checker.sv
dv/tb_countdown_timer_pool_unit.sv
